[rtl/image_header_geometry_sniffer_assert.svh]
// Assertion macros for the header sniffer checker
`ifndef IMAGE_HEADER_GEOMETRY_SNIFFER_ASSERT_SVH
`define IMAGE_HEADER_GEOMETRY_SNIFFER_ASSERT_SVH
`define IHGS_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define IHGS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[rtl/ihgs_pkg.sv]
// ----------------------------------------------------------------------------
// ihgs_pkg
// Types and constants of the image header geometry sniffer.
// ----------------------------------------------------------------------------
package ihgs_pkg;
  typedef enum logic [3:0] {
    PH_SIG, PH_IDLE, PH_PNG_HEAD, PH_PNG_PHYS, PH_PNG_SKIP, PH_JPG_SCAN,
    PH_JPG_MARK, PH_JPG_LEN, PH_JPG_SOF, PH_JPG_APP, PH_JPG_SKIP
  } phase_t;
  localparam logic [2:0] FMT_NONE = 3'd0;
  localparam logic [2:0] FMT_PNG  = 3'd1;
  localparam logic [2:0] FMT_JPEG = 3'd2;
  localparam logic [2:0] FMT_BMP  = 3'd3;
  localparam logic [2:0] FMT_GIF  = 3'd4;
  localparam logic [31:0] TAG_IDAT = 32'h49444154;
  localparam logic [31:0] TAG_IEND = 32'h49454E44;
  localparam logic [31:0] TAG_PHYS = 32'h70485973;
  localparam logic [31:0] TAG_IHDR = 32'h49484452;
  localparam logic [63:0] PNG_SIG  = 64'h89504E470D0A1A0A;
  localparam logic [31:0] GIF_SIG  = 32'h47494638;
  localparam logic [39:0] JFIF_TAG = 40'h4A46494600;
  localparam logic [15:0] CENTI    = 16'd100;
  typedef struct packed {
    logic        recognised;
    logic [2:0]  image_format;
    logic [30:0] image_width;
    logic [30:0] image_height;
    logic [1:0]  resolution_unit;
    logic [31:0] resolution_x_centi;
    logic [31:0] resolution_y_centi;
  } result_t;
endpackage

[rtl/ihgs_if.sv]
// ----------------------------------------------------------------------------
// ihgs_in_if / ihgs_out_if
// Valid/ready channels for file bytes and results.
// ----------------------------------------------------------------------------
interface ihgs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface ihgs_out_if;
  logic                 valid;
  logic                 ready;
  ihgs_pkg::result_t    res;
  modport source (output valid, res, input ready);
  modport sink (input valid, res, output ready);
endinterface

[rtl/image_header_geometry_sniffer.sv]
// ----------------------------------------------------------------------------
// image_header_geometry_sniffer
// Byte-stream parser for PNG, JPEG, BMP and GIF headers.
// ----------------------------------------------------------------------------
// One byte is taken per cycle whenever the result register is free or being
// drained; a byte flagged last_byte yields one result via the byte register and
// then the result register. The byte register feeds parse logic that updates
// the state registers (a few 32-bit compares, two 16x7 JFIF multiplies).
module image_header_geometry_sniffer (
  input logic clk,
  input logic rst,
  ihgs_in_if.sink   in_ch,
  ihgs_out_if.source out_ch
);
  logic        bv, blast;
  logic [7:0]  bb;
  ihgs_pkg::phase_t ph, ph_next;
  logic [5:0]  off, off_next;
  logic [32:0] skip, skip_next;
  logic [31:0] gw, gw_next, slen, slen_next, stag, stag_next;
  logic [7:0]  mk, mk_next;
  logic [2:0]  fmt, fmt_next;
  logic [31:0] hw, hw_next, hh, hh_next, rx, rx_next, ry, ry_next;
  logic [1:0]  un, un_next;
  logic [1:0]  pl, pl_next, pu, pu_next;
  logic [31:0] px, px_next, py, py_next;
  logic        am, am_next;
  ihgs_pkg::result_t res_next;
  logic        stall;
  logic [32:0] idx;
  logic [31:0] h_abs;
  logic        ok;
  logic [5:0]  n;

  assign stall = out_ch.valid && !out_ch.ready;
  assign in_ch.ready = !stall;

  always_ff @(posedge clk) begin
    if (rst) bv <= 1'b0;
    else if (!stall) bv <= in_ch.valid;
    if (in_ch.valid && in_ch.ready) begin
      bb <= in_ch.data_byte;
      blast <= in_ch.last_byte;
    end
  end

  function automatic logic is_sof(input logic [7:0] m);
    return m >= 8'hC0 && m <= 8'hCF && m != 8'hC4 && m != 8'hC8 && m != 8'hCC;
  endfunction

  function automatic logic size_ok(input logic [31:0] v);
    return v != 32'd0 && !v[31];
  endfunction

  always_comb begin
    ph_next = ph; off_next = off; skip_next = skip; gw_next = gw;
    slen_next = slen; stag_next = stag; mk_next = mk; fmt_next = fmt;
    hw_next = hw; hh_next = hh; rx_next = rx; ry_next = ry; un_next = un;
    pl_next = pl; pu_next = pu; px_next = px; py_next = py; am_next = am;
    idx = '0; h_abs = '0; ok = 1'b0; n = '0; res_next = '0;
    if (ph == ihgs_pkg::PH_SIG) begin
      ph_next = ihgs_pkg::PH_IDLE;
      unique case (bb)
        8'h89: begin
          fmt_next = ihgs_pkg::FMT_PNG; ph_next = ihgs_pkg::PH_PNG_HEAD; skip_next = 33'd8;
        end
        8'hFF: begin fmt_next = ihgs_pkg::FMT_JPEG; ph_next = ihgs_pkg::PH_JPG_SCAN; end
        8'h42: fmt_next = ihgs_pkg::FMT_BMP;
        8'h47: fmt_next = ihgs_pkg::FMT_GIF;
        default: fmt_next = ihgs_pkg::FMT_NONE;
      endcase
    end else begin
      unique case (fmt)
        ihgs_pkg::FMT_PNG: begin
          if (off < 6'd8) begin
            if (bb != ihgs_pkg::PNG_SIG[8'(7 - off) * 8 +: 8]) begin
              fmt_next = ihgs_pkg::FMT_NONE; ph_next = ihgs_pkg::PH_IDLE;
            end
          end else if (off >= 6'd12 && off < 6'd16) begin
            if (bb != ihgs_pkg::TAG_IHDR[8'(15 - off) * 8 +: 8]) begin
              fmt_next = ihgs_pkg::FMT_NONE; ph_next = ihgs_pkg::PH_IDLE;
            end
          end else if (off >= 6'd16 && off < 6'd20) hw_next = {hw[23:0], bb};
          else if (off >= 6'd20 && off < 6'd24) hh_next = {hh[23:0], bb};
        end
        ihgs_pkg::FMT_JPEG: begin
          if (off == 6'd1 && bb != 8'hD8) begin
            fmt_next = ihgs_pkg::FMT_NONE; ph_next = ihgs_pkg::PH_IDLE;
          end
        end
        ihgs_pkg::FMT_BMP: begin
          if (off == 6'd1) begin
            if (bb != 8'h4D) begin fmt_next = ihgs_pkg::FMT_NONE; ph_next = ihgs_pkg::PH_IDLE; end
          end else if (off >= 6'd18 && off < 6'd22) hw_next[2'(off - 6'd18) * 8 +: 8] = bb;
          else if (off >= 6'd22 && off < 6'd26) hh_next[2'(off - 6'd22) * 8 +: 8] = bb;
        end
        ihgs_pkg::FMT_GIF: begin
          if (off < 6'd4) begin
            if (bb != ihgs_pkg::GIF_SIG[2'(3 - off) * 8 +: 8]) begin
              fmt_next = ihgs_pkg::FMT_NONE; ph_next = ihgs_pkg::PH_IDLE;
            end
          end else if (off >= 6'd6 && off < 6'd8) hw_next[off[0] * 8 +: 8] = bb;
          else if (off >= 6'd8 && off < 6'd10) hh_next[off[0] * 8 +: 8] = bb;
        end
        default: ;
      endcase
      // walks use post-check format (signature bytes precede walk offsets)
      if (fmt_next == ihgs_pkg::FMT_PNG && off >= 6'd8) begin
        unique case (ph)
          ihgs_pkg::PH_PNG_HEAD: begin
            gw_next = {gw[23:0], bb};
            skip_next = skip - 33'd1;
            if (skip_next == 33'd4) slen_next = gw_next;
            if (skip_next == 33'd0) begin
              stag_next = gw_next;
              if (gw_next == ihgs_pkg::TAG_IDAT || gw_next == ihgs_pkg::TAG_IEND)
                ph_next = ihgs_pkg::PH_IDLE;
              else if (gw_next == ihgs_pkg::TAG_PHYS && slen >= 32'd9) begin
                ph_next = ihgs_pkg::PH_PNG_PHYS; skip_next = 33'd9;
              end else begin
                ph_next = ihgs_pkg::PH_PNG_SKIP; skip_next = {1'b0, slen} + 33'd4;
              end
            end
          end
          ihgs_pkg::PH_PNG_PHYS: begin
            idx = 33'd9 - skip;
            if (idx < 33'd8) gw_next = {gw[23:0], bb};
            if (idx == 33'd3) stag_next = gw_next;
            if (idx == 33'd8 && bb == 8'd1) begin
              rx_next = stag; ry_next = gw; un_next = 2'd2;
            end
            skip_next = skip - 33'd1;
            if (skip_next == 33'd0) begin
              ph_next = ihgs_pkg::PH_PNG_SKIP;
              skip_next = {1'b0, slen} - 33'd5;
            end
          end
          ihgs_pkg::PH_PNG_SKIP: begin
            skip_next = skip - 33'd1;
            if (skip_next == 33'd0) begin ph_next = ihgs_pkg::PH_PNG_HEAD; skip_next = 33'd8; end
          end
          default: ;
        endcase
      end else if (fmt_next == ihgs_pkg::FMT_JPEG && off >= 6'd2) begin
        if (pl != 2'd0) begin
          pl_next = pl - 2'd1;
          if (pl_next == 2'd0) begin rx_next = px; ry_next = py; un_next = pu; end
        end
        unique case (ph)
          ihgs_pkg::PH_JPG_SCAN: if (bb == 8'hFF) ph_next = ihgs_pkg::PH_JPG_MARK;
          ihgs_pkg::PH_JPG_MARK: begin
            mk_next = bb;
            if (bb == 8'hD8 || bb == 8'h01 || (bb >= 8'hD0 && bb <= 8'hD7))
              ph_next = ihgs_pkg::PH_JPG_SCAN;
            else begin
              ph_next = ihgs_pkg::PH_JPG_LEN; skip_next = 33'd2; slen_next = '0;
            end
          end
          ihgs_pkg::PH_JPG_LEN: begin
            slen_next = {16'd0, slen[7:0], bb};
            skip_next = skip - 33'd1;
            if (skip_next == 33'd0) begin
              if (is_sof(mk)) begin ph_next = ihgs_pkg::PH_JPG_SOF; skip_next = 33'd5; end
              else if (mk == 8'hE0 && slen_next >= 32'd14) begin
                ph_next = ihgs_pkg::PH_JPG_APP; skip_next = 33'd12; am_next = 1'b1;
              end else if (slen_next <= 32'd2) ph_next = ihgs_pkg::PH_JPG_SCAN;
              else begin
                ph_next = ihgs_pkg::PH_JPG_SKIP; skip_next = {1'b0, slen_next - 32'd2};
              end
            end
          end
          ihgs_pkg::PH_JPG_SOF: begin
            gw_next = {gw[23:0], bb};
            skip_next = skip - 33'd1;
            if (skip_next == 33'd0) begin
              hh_next = {16'd0, gw_next[31:16]}; hw_next = {16'd0, gw_next[15:0]};
              ph_next = ihgs_pkg::PH_IDLE;
            end
          end
          ihgs_pkg::PH_JPG_APP: begin
            idx = 33'd12 - skip;
            if (idx < 33'd5 && bb != ihgs_pkg::JFIF_TAG[3'(4 - idx[2:0]) * 8 +: 8])
              am_next = 1'b0;
            if (idx == 33'd7) stag_next = {24'd0, bb};
            if (idx >= 33'd8) gw_next = {gw[23:0], bb};
            skip_next = skip - 33'd1;
            if (skip_next == 33'd0) begin
              if (am && (stag == 32'd1 || stag == 32'd2)) begin
                pu_next = stag[1:0];
                px_next = gw_next[31:16] * ihgs_pkg::CENTI;
                py_next = gw_next[15:0] * ihgs_pkg::CENTI;
                pl_next = 2'd2;
              end
              if (slen == 32'd14) ph_next = ihgs_pkg::PH_JPG_SCAN;
              else begin
                ph_next = ihgs_pkg::PH_JPG_SKIP; skip_next = {1'b0, slen - 32'd14};
              end
            end
          end
          ihgs_pkg::PH_JPG_SKIP: begin
            skip_next = skip - 33'd1;
            if (skip_next == 33'd0) ph_next = ihgs_pkg::PH_JPG_SCAN;
          end
          default: ;
        endcase
      end
    end
    if (off < 6'd63) off_next = off + 6'd1;
    n = off_next;
    h_abs = hh_next[31] ? 32'd0 - hh_next : hh_next;
    unique case (fmt_next)
      ihgs_pkg::FMT_PNG: ok = n >= 6'd33 && size_ok(hw_next) && size_ok(hh_next);
      ihgs_pkg::FMT_JPEG: ok = size_ok(hw_next) && size_ok(hh_next);
      ihgs_pkg::FMT_BMP: ok = n >= 6'd30 && size_ok(hw_next) && size_ok(h_abs);
      ihgs_pkg::FMT_GIF: ok = n >= 6'd10 && size_ok(hw_next) && size_ok(hh_next);
      default: ok = 1'b0;
    endcase
    if (ok) begin
      res_next.recognised = 1'b1;
      res_next.image_format = fmt_next;
      res_next.image_width = hw_next[30:0];
      res_next.image_height = fmt_next == ihgs_pkg::FMT_BMP ? h_abs[30:0] : hh_next[30:0];
      if (un_next != 2'd0) begin
        res_next.resolution_unit = un_next;
        res_next.resolution_x_centi = rx_next;
        res_next.resolution_y_centi = ry_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (bv && !stall && blast)) begin
      ph <= ihgs_pkg::PH_SIG; off <= '0; skip <= '0; gw <= '0; slen <= '0;
      stag <= '0; mk <= '0; fmt <= ihgs_pkg::FMT_NONE; hw <= '0; hh <= '0;
      rx <= '0; ry <= '0; un <= '0; pl <= '0; pu <= '0; px <= '0; py <= '0;
      am <= 1'b0;
    end else if (bv && !stall) begin
      ph <= ph_next; off <= off_next; skip <= skip_next; gw <= gw_next;
      slen <= slen_next; stag <= stag_next; mk <= mk_next; fmt <= fmt_next;
      hw <= hw_next; hh <= hh_next; rx <= rx_next; ry <= ry_next; un <= un_next;
      pl <= pl_next; pu <= pu_next; px <= px_next; py <= py_next; am <= am_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (!stall) out_ch.valid <= bv && blast;
    if (!stall && bv && blast) out_ch.res <= res_next;
  end
endmodule

[rtl/ihgs_checker.sv]
// ----------------------------------------------------------------------------
// ihgs_checker
// Port-level checks on the sniffer results.
// ----------------------------------------------------------------------------
`include "image_header_geometry_sniffer_assert.svh"
module ihgs_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic in_ready,
  input ihgs_pkg::result_t res
);
  `IHGS_ASSERT_IMPL(unrec_zero, clk, rst, out_valid && !res.recognised, res == '0)
  `IHGS_ASSERT_IMPL(rec_fmt, clk, rst, out_valid && res.recognised,
    res.image_format != ihgs_pkg::FMT_NONE && res.image_width != '0)
  `IHGS_ASSERT_IMPL(stall_ready, clk, rst, out_valid && !out_ready, !in_ready)
  `IHGS_ASSERT_IMPL(unit_res, clk, rst, out_valid && res.resolution_unit == 2'd0,
    res.resolution_x_centi == '0 && res.resolution_y_centi == '0)
endmodule

bind image_header_geometry_sniffer ihgs_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .in_ready(in_ch.ready), .res(out_ch.res)
);

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the image header geometry sniffer: streams PNG,
// JPEG, BMP and GIF files (well-formed, truncated, corrupted and noise) and
// compares every result with an in-bench header parser.
// ----------------------------------------------------------------------------
module tb_top;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ihgs_in_if in_ch ();
  ihgs_out_if out_ch ();

  image_header_geometry_sniffer u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  localparam int LIMIT = 2000000;

  ihgs_pkg::result_t exp_results[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  byte unsigned file_buf[$];

  // parser state
  ihgs_pkg::phase_t ph;
  logic [5:0] offs;
  logic [32:0] skip;
  logic [31:0] gword, seg_len, seg_tag, w_h, h_h, rx_h, ry_h, p_x, p_y;
  logic [7:0] mcode;
  logic [2:0] fmt_h;
  logic [1:0] unit_h, p_unit;
  logic [1:0] p_left;
  bit app_ok;

  function automatic bit size_good(logic [31:0] v);
    return v != 0 && v[31] == 1'b0;
  endfunction

  task automatic parser_clear();
    ph = ihgs_pkg::PH_SIG; offs = '0; skip = '0; gword = '0; seg_len = '0; seg_tag = '0;
    mcode = '0; fmt_h = ihgs_pkg::FMT_NONE; w_h = '0; h_h = '0; rx_h = '0; ry_h = '0;
    unit_h = '0; p_left = '0; p_unit = '0; p_x = '0; p_y = '0; app_ok = 1'b0;
  endtask

  task automatic header_byte(int o, logic [7:0] b);
    bit bad;
    bad = 0;
    case (fmt_h)
      ihgs_pkg::FMT_PNG: begin
        if (o < 8) bad = b != ihgs_pkg::PNG_SIG[63 - 8*o -: 8];
        else if (o >= 12 && o < 16) bad = b != ihgs_pkg::TAG_IHDR[31 - 8*(o-12) -: 8];
        else if (o >= 16 && o < 20) w_h = {w_h[23:0], b};
        else if (o >= 20 && o < 24) h_h = {h_h[23:0], b};
      end
      ihgs_pkg::FMT_JPEG: if (o == 1) bad = b != 8'hD8;
      ihgs_pkg::FMT_BMP: begin
        if (o == 1) bad = b != 8'h4D;
        else if (o >= 18 && o < 22) w_h |= 32'(b) << (8*(o-18));
        else if (o >= 22 && o < 26) h_h |= 32'(b) << (8*(o-22));
      end
      ihgs_pkg::FMT_GIF: begin
        if (o < 4) bad = b != ihgs_pkg::GIF_SIG[31 - 8*o -: 8];
        else if (o >= 6 && o < 8) w_h |= 32'(b) << (8*(o-6));
        else if (o >= 8 && o < 10) h_h |= 32'(b) << (8*(o-8));
      end
      default: ;
    endcase
    if (bad) begin
      fmt_h = ihgs_pkg::FMT_NONE;
      ph = ihgs_pkg::PH_IDLE;
    end
  endtask

  task automatic png_step(logic [7:0] b);
    int idx;
    case (ph)
      ihgs_pkg::PH_PNG_HEAD: begin
        gword = {gword[23:0], b};
        skip--;
        if (skip == 4) seg_len = gword;
        if (skip == 0) begin
          seg_tag = gword;
          if (seg_tag == ihgs_pkg::TAG_IDAT || seg_tag == ihgs_pkg::TAG_IEND)
            ph = ihgs_pkg::PH_IDLE;
          else if (seg_tag == ihgs_pkg::TAG_PHYS && seg_len >= 9) begin
            ph = ihgs_pkg::PH_PNG_PHYS; skip = 33'd9;
          end else begin
            ph = ihgs_pkg::PH_PNG_SKIP; skip = {1'b0, seg_len} + 33'd4;
          end
        end
      end
      ihgs_pkg::PH_PNG_PHYS: begin
        idx = 9 - int'(skip);
        if (idx < 8) gword = {gword[23:0], b};
        if (idx == 3) seg_tag = gword;
        if (idx == 8 && b == 1) begin
          rx_h = seg_tag; ry_h = gword; unit_h = 2'd2;
        end
        skip--;
        if (skip == 0) begin
          ph = ihgs_pkg::PH_PNG_SKIP; skip = {1'b0, seg_len} - 33'd5;
        end
      end
      ihgs_pkg::PH_PNG_SKIP: begin
        skip--;
        if (skip == 0) begin
          ph = ihgs_pkg::PH_PNG_HEAD; skip = 33'd8;
        end
      end
      default: ;
    endcase
  endtask

  task automatic jpeg_step(logic [7:0] b);
    int idx;
    logic [31:0] rest;
    if (p_left != 0) begin
      p_left--;
      if (p_left == 0) begin
        rx_h = p_x; ry_h = p_y; unit_h = p_unit;
      end
    end
    case (ph)
      ihgs_pkg::PH_JPG_SCAN: if (b == 8'hFF) ph = ihgs_pkg::PH_JPG_MARK;
      ihgs_pkg::PH_JPG_MARK: begin
        mcode = b;
        if (b == 8'hD8 || b == 8'h01 || (b >= 8'hD0 && b <= 8'hD7)) ph = ihgs_pkg::PH_JPG_SCAN;
        else begin
          ph = ihgs_pkg::PH_JPG_LEN; skip = 33'd2; seg_len = '0;
        end
      end
      ihgs_pkg::PH_JPG_LEN: begin
        seg_len = {16'h0, seg_len[7:0], b};
        skip--;
        if (skip == 0) begin
          if (mcode >= 8'hC0 && mcode <= 8'hCF && mcode != 8'hC4 && mcode != 8'hC8
              && mcode != 8'hCC) begin
            ph = ihgs_pkg::PH_JPG_SOF; skip = 33'd5;
          end else if (mcode == 8'hE0 && seg_len >= 14) begin
            ph = ihgs_pkg::PH_JPG_APP; skip = 33'd12; app_ok = 1;
          end else begin
            rest = seg_len <= 2 ? 32'd0 : seg_len - 32'd2;
            if (rest == 0) ph = ihgs_pkg::PH_JPG_SCAN;
            else begin
              ph = ihgs_pkg::PH_JPG_SKIP; skip = {1'b0, rest};
            end
          end
        end
      end
      ihgs_pkg::PH_JPG_SOF: begin
        gword = {gword[23:0], b};
        skip--;
        if (skip == 0) begin
          h_h = {16'h0, gword[31:16]}; w_h = {16'h0, gword[15:0]}; ph = ihgs_pkg::PH_IDLE;
        end
      end
      ihgs_pkg::PH_JPG_APP: begin
        idx = 12 - int'(skip);
        if (idx < 5 && b != ihgs_pkg::JFIF_TAG[39 - 8*idx -: 8]) app_ok = 0;
        if (idx == 7) seg_tag = {24'h0, b};
        if (idx >= 8) gword = {gword[23:0], b};
        skip--;
        if (skip == 0) begin
          if (app_ok && (seg_tag == 1 || seg_tag == 2)) begin
            p_unit = seg_tag[1:0];
            p_x = {16'h0, gword[31:16]} * 32'(ihgs_pkg::CENTI);
            p_y = {16'h0, gword[15:0]} * 32'(ihgs_pkg::CENTI);
            p_left = 2'd2;
          end
          rest = seg_len - 32'd14;
          if (rest == 0) ph = ihgs_pkg::PH_JPG_SCAN;
          else begin
            ph = ihgs_pkg::PH_JPG_SKIP; skip = {1'b0, rest};
          end
        end
      end
      ihgs_pkg::PH_JPG_SKIP: begin
        skip--;
        if (skip == 0) ph = ihgs_pkg::PH_JPG_SCAN;
      end
      default: ;
    endcase
  endtask

  task automatic parse_byte(logic [7:0] b, bit last);
    int o;
    bit ok;
    ihgs_pkg::result_t r;
    o = offs;
    if (ph == ihgs_pkg::PH_SIG) begin
      ph = ihgs_pkg::PH_IDLE;
      case (b)
        8'h89: begin
          fmt_h = ihgs_pkg::FMT_PNG; ph = ihgs_pkg::PH_PNG_HEAD; skip = 33'd8;
        end
        8'hFF: begin fmt_h = ihgs_pkg::FMT_JPEG; ph = ihgs_pkg::PH_JPG_SCAN; end
        8'h42: fmt_h = ihgs_pkg::FMT_BMP;
        8'h47: fmt_h = ihgs_pkg::FMT_GIF;
        default: fmt_h = ihgs_pkg::FMT_NONE;
      endcase
    end else begin
      header_byte(o, b);
      if (fmt_h == ihgs_pkg::FMT_PNG && o >= 8) png_step(b);
      else if (fmt_h == ihgs_pkg::FMT_JPEG && o >= 2) jpeg_step(b);
    end
    if (offs < 63) offs++;
    if (!last) return;
    ok = 0;
    case (fmt_h)
      ihgs_pkg::FMT_PNG: ok = offs >= 33 && size_good(w_h) && size_good(h_h);
      ihgs_pkg::FMT_JPEG: ok = size_good(w_h) && size_good(h_h);
      ihgs_pkg::FMT_BMP: begin
        if (h_h[31]) h_h = -h_h;
        ok = offs >= 30 && size_good(w_h) && size_good(h_h);
      end
      ihgs_pkg::FMT_GIF: ok = offs >= 10 && size_good(w_h) && size_good(h_h);
      default: ;
    endcase
    r = '0;
    if (ok) begin
      r.recognised = 1; r.image_format = fmt_h;
      r.image_width = w_h[30:0]; r.image_height = h_h[30:0];
      if (unit_h != 0) begin
        r.resolution_unit = unit_h;
        r.resolution_x_centi = rx_h; r.resolution_y_centi = ry_h;
      end
    end
    exp_results.push_back(r);
    parser_clear();
  endtask

  // ---------------- driving ----------------
  task automatic send_byte(logic [7:0] b, bit last);
    while (!calm && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    parse_byte(b, last);
  endtask

  task automatic send_file();
    foreach (file_buf[i]) send_byte(file_buf[i], i == file_buf.size() - 1);
    file_buf.delete();
  endtask

  task automatic put_be(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) file_buf.push_back(v[8*i +: 8]);
  endtask

  task automatic put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_buf.push_back(v[8*i +: 8]);
  endtask

  function automatic logic [31:0] rand_dim();
    case ($urandom_range(7))
      0: return 0;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000 | $urandom;
      3: return 1;
      default: return $urandom_range(1, 5000);
    endcase
  endfunction

  task automatic build_png(logic [31:0] w, logic [31:0] h, int nphys);
    logic [31:0] len;
    put_be(ihgs_pkg::PNG_SIG[63:32], 4); put_be(ihgs_pkg::PNG_SIG[31:0], 4);
    put_be(13, 4); put_be(ihgs_pkg::TAG_IHDR, 4); put_be(w, 4); put_be(h, 4);
    put_be($urandom, 4); put_be($urandom, 1); put_be($urandom, 4);
    for (int k = 0; k < nphys; k++) begin
      if ($urandom_range(3) == 0) begin
        len = $urandom_range(0, 6);
        put_be(len, 4); put_be($urandom, 4);
        for (int i = 0; i < len; i++) put_be($urandom, 1);
      end else begin
        len = $urandom_range(3) == 0 ? $urandom_range(0, 12) : 9;
        put_be(len, 4); put_be(ihgs_pkg::TAG_PHYS, 4);
        for (int i = 0; i < len; i++)
          put_be(i == 8 ? ($urandom_range(2) != 0 ? 1 : $urandom) : $urandom, 1);
      end
      put_be($urandom, 4);
    end
    put_be(0, 4); put_be($urandom_range(1) ? ihgs_pkg::TAG_IDAT : ihgs_pkg::TAG_IEND, 4);
    put_be($urandom, 4);
  endtask

  task automatic build_jpeg(logic [15:0] w, logic [15:0] h);
    int n;
    logic [15:0] len;
    put_be(16'hFFD8, 2);
    n = $urandom_range(0, 3);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(4))
        0: begin
          len = $urandom_range(3) == 0 ? $urandom_range(0, 20) : 16;
          put_be(16'hFFE0, 2); put_be(len, 2);
          if ($urandom_range(3) != 0) put_be(32'h4A464946, 4);
          else put_be($urandom, 4);
          put_be($urandom_range(3) ? 0 : $urandom, 1); put_be($urandom, 2);
          put_be($urandom_range(3), 1); put_be($urandom, 4);
          for (int i = 16; i < len; i++) put_be($urandom, 1);
        end
        1: put_be({8'hFF, 8'hD0 | 8'($urandom_range(7))}, 2);
        2: put_be($urandom_range(0, 254), 1);
        3: begin
          put_be({8'hFF, $urandom_range(3) ? 8'hC4 : 8'hE1}, 2);
          len = $urandom_range(0, 6);
          put_be(len, 2);
          for (int i = 2; i < len; i++) put_be($urandom, 1);
        end
        default: put_be(16'hFF01, 2);
      endcase
    end
    put_be({8'hFF, 8'hC0 | 8'($urandom_range(15))}, 2); put_be(17, 2);
    put_be(8, 1); put_be(h, 2); put_be(w, 2); put_be($urandom, 3);
  endtask

  task automatic build_bmp(logic [31:0] w, logic [31:0] h);
    put_be(16'h424D, 2);
    for (int i = 2; i < 18; i++) put_be($urandom, 1);
    put_le(w, 4); put_le(h, 4);
    for (int i = 0; i < $urandom_range(4, 10); i++) put_be($urandom, 1);
  endtask

  task automatic build_gif(logic [15:0] w, logic [15:0] h);
    put_be(ihgs_pkg::GIF_SIG, 4); put_be($urandom_range(1) ? 16'h3961 : 16'h3761, 2);
    put_le(w, 2); put_le(h, 2);
    for (int i = 0; i < $urandom_range(0, 5); i++) put_be($urandom, 1);
  endtask

  task automatic mangle();
    int k;
    if ($urandom_range(1)) begin
      k = $urandom_range(1, file_buf.size());
      while (file_buf.size() > k) void'(file_buf.pop_back());
    end else begin
      k = $urandom_range(0, file_buf.size() - 1);
      file_buf[k] = $urandom;
    end
  endtask

  task automatic random_file();
    case ($urandom_range(9))
      0, 1: build_png(rand_dim(), rand_dim(), $urandom_range(0, 3));
      2, 3: build_jpeg($urandom, $urandom_range(3) ? $urandom_range(1, 900) : 0);
      4: build_bmp(rand_dim(), $urandom_range(1) ? -rand_dim() : rand_dim());
      5: build_gif($urandom, $urandom);
      6: for (int i = 0; i < $urandom_range(1, 40); i++) put_be($urandom, 1);
      default: begin
        random_file();
        mangle();
      end
    endcase
  endtask

  // ---------------- tests ----------------
  task automatic test_png();
    build_png(1, 1, 0); send_file();
    build_png(32'h7FFFFFFF, 32'h7FFFFFFF, 2); send_file();
    build_png(32'h80000000, 5, 0); send_file();
    build_png(0, 5, 1); send_file();
    build_png(640, 480, 1); void'(file_buf.pop_back()); send_file();
    build_png(640, 480, 0);
    while (file_buf.size() > 32) void'(file_buf.pop_back());
    send_file();
  endtask

  task automatic test_jpeg();
    build_jpeg(16'hFFFF, 16'hFFFF); send_file();
    build_jpeg(1, 0); send_file();
    build_jpeg(320, 200); void'(file_buf.pop_back()); send_file();
    put_be(16'hFFD8, 2); put_be(16'hFFE0, 2); put_be(16, 2); put_be(32'h4A464946, 4);
    put_be(0, 3); put_be(1, 1); put_be(32'hFFFF0048, 4); put_be(0, 2);
    put_be(32'hFFC00011, 4); put_be(8, 1); put_be(32'h00100020, 4); put_be(0, 1);
    send_file();
    put_be(16'hFFD8, 2); put_be(16'hFFC4, 2); put_be(1, 2);
    put_be(32'hFFC20011, 4); put_be(8, 1); put_be(32'h00010001, 4); put_be(0, 1);
    send_file();
  endtask

  task automatic test_bmp_gif();
    build_bmp(1, -1); send_file();
    build_bmp(32'h7FFFFFFF, 32'h80000000); send_file();
    build_bmp(100, 0); send_file();
    build_bmp(100, 200);
    while (file_buf.size() > 29) void'(file_buf.pop_back());
    send_file();
    build_gif(16'hFFFF, 16'hFFFF); send_file();
    build_gif(0, 9); send_file();
    build_gif(3, 4);
    while (file_buf.size() > 9) void'(file_buf.pop_back());
    send_file();
  endtask

  task automatic test_noise();
    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    put_be(32'h42000000, 4); send_file();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 1260) begin
      calm = (sent > 400 && sent < 600);
      random_file();
      sent += file_buf.size();
      send_file();
    end
    calm = 1'b0;
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || $urandom_range(99) >= 13;
  end

  always @(posedge clk) begin
    ihgs_pkg::result_t e, a;
    if (!rst && out_ch.valid && out_ch.ready) begin
      a = out_ch.res;
      if (exp_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, a);
        errors++;
      end else begin
        e = exp_results.pop_front();
        if (a.recognised !== e.recognised)
          $display("%0t: recognised exp %0d got %0d", $time, e.recognised, a.recognised);
        if (a.image_format !== e.image_format)
          $display("%0t: format exp %0d got %0d", $time, e.image_format, a.image_format);
        if (a.image_width !== e.image_width)
          $display("%0t: width exp %0d got %0d", $time, e.image_width, a.image_width);
        if (a.image_height !== e.image_height)
          $display("%0t: height exp %0d got %0d", $time, e.image_height, a.image_height);
        if (a.resolution_unit !== e.resolution_unit)
          $display("%0t: unit exp %0d got %0d", $time, e.resolution_unit,
                   a.resolution_unit);
        if (a.resolution_x_centi !== e.resolution_x_centi)
          $display("%0t: res_x exp %0d got %0d", $time, e.resolution_x_centi,
                   a.resolution_x_centi);
        if (a.resolution_y_centi !== e.resolution_y_centi)
          $display("%0t: res_y exp %0d got %0d", $time, e.resolution_y_centi,
                   a.resolution_y_centi);
        if (a !== e) errors++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("image_header_geometry_sniffer verification failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    parser_clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_png();
    test_jpeg();
    test_bmp_gif();
    test_noise();
    test_random();
    in_ch.valid <= 1'b0;
    while (exp_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("image_header_geometry_sniffer verification clean");
    else $display("image_header_geometry_sniffer verification failed");
    $finish;
  end
endmodule
